### src/plldiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plldiv_pkg
// Shared types and constants of the PLL divider search core.
// ----------------------------------------------------------------------------
package plldiv_pkg;

  localparam int REF_W   = 17;
  localparam int OUTMIN_W = 21;
  localparam int VCO_W   = 24;
  localparam int RATE_W  = 21;
  localparam int M_W     = 8;
  localparam int N_W     = 4;
  localparam int E_W     = 2;
  localparam int ST_W    = 2;
  localparam int PROD_W  = VCO_W + N_W;
  localparam int PFD_W   = 20;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [M_W-1:0] M_MAX   = 8'hff;
  localparam logic [N_W-1:0] N_MAX   = 4'hf;
  localparam logic [E_W-1:0] E_MAX   = 2'd3;
  localparam logic [PFD_W-1:0] PFD_MIN = 20'd1000;
  localparam logic [PFD_W-1:0] PFD_MAX = 20'd50000;

  localparam logic [REF_W-1:0]    REF_RST    = 17'd25000;
  localparam logic [OUTMIN_W-1:0] OUTMIN_RST = 21'd62500;
  localparam logic [VCO_W-1:0]    VCOMIN_RST = 24'd500000;
  localparam logic [VCO_W-1:0]    VCOMAX_RST = 24'd1500000;

  // register indexes
  localparam logic [1:0] REG_REF    = 2'd0;
  localparam logic [1:0] REG_OUTMIN = 2'd1;
  localparam logic [1:0] REG_VCOMIN = 2'd2;
  localparam logic [1:0] REG_VCOMAX = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_EXP = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_MN  = 2'd3;

  typedef struct packed {
    logic [REF_W-1:0]    ref_clk;
    logic [OUTMIN_W-1:0] out_min;
    logic [VCO_W-1:0]    vco_min;
    logic [VCO_W-1:0]    vco_max;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/plldiv_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plldiv_regs
// Configuration register bank behind a simple APB-style port.
// ----------------------------------------------------------------------------
module plldiv_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plldiv_pkg::ADDR_W-1:0] paddr,
  input  logic [plldiv_pkg::DATA_W-1:0] pwdata,
  output logic [plldiv_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output plldiv_pkg::cfg_t              cfg
);
  import plldiv_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_clk <= REF_RST;
      cfg.out_min <= OUTMIN_RST;
      cfg.vco_min <= VCOMIN_RST;
      cfg.vco_max <= VCOMAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_REF:    cfg.ref_clk <= pwdata[REF_W-1:0];
        REG_OUTMIN: cfg.out_min <= pwdata[OUTMIN_W-1:0];
        REG_VCOMIN: cfg.vco_min <= pwdata[VCO_W-1:0];
        REG_VCOMAX: cfg.vco_max <= pwdata[VCO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REF:    prdata = DATA_W'(cfg.ref_clk);
      REG_OUTMIN: prdata = DATA_W'(cfg.out_min);
      REG_VCOMIN: prdata = DATA_W'(cfg.vco_min);
      REG_VCOMAX: prdata = DATA_W'(cfg.vco_max);
      default:    prdata = '0;
    endcase
  end

endmodule

### src/plldiv_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plldiv_divider
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// ----------------------------------------------------------------------------
module plldiv_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [plldiv_pkg::PROD_W-1:0] dividend,
  input  logic [plldiv_pkg::REF_W-1:0]  divisor,
  output logic [plldiv_pkg::M_W-1:0]    quotient,
  output plldiv_pkg::div_stat_t         stat
);
  import plldiv_pkg::*;

  localparam int DSR_W = REF_W + M_W - 1;

  logic [PROD_W-1:0]   rem;
  logic [DSR_W-1:0]    dsr;
  logic [2:0]          count;
  logic                ge;

  assign ge = rem >= PROD_W'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      count <= '0;
    end else begin
      stat.done <= stat.busy && (count == 3'd7);
      if (start && !stat.busy) begin
        stat.busy <= 1'b1;
        count     <= '0;
      end else if (stat.busy) begin
        count <= count + 3'd1;
        if (count == 3'd7) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !stat.busy) begin
      rem      <= dividend;
      dsr      <= {divisor, {(M_W-1){1'b0}}};
      quotient <= '0;
    end else if (stat.busy) begin
      if (ge) rem <= rem - PROD_W'(dsr);
      dsr      <= {1'b0, dsr[DSR_W-1:1]};
      quotient <= {quotient[M_W-2:0], ge};
    end
  end

endmodule

### src/pll_divider_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_search_core
// Searches PLL post divider, reference divider and multiplier for a rate.
// ----------------------------------------------------------------------------
// sequence: range check first, and a rejected rate goes straight to the output
// register; otherwise a trial per post divider exponent, a multiply and a check
// per reference divider trial, a division for the winning multiplier, then the
// output register load, held by any output stall; throughput: one search at
// a time, the next transfer is taken once the result is in the output register
// reset: synchronous, clears control state and restores register defaults
module pll_divider_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // target_khz[20:0], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], mult_m[9:2], prediv_n[13:10], postdiv_exp[15:14]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import plldiv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RANGE  = 3'd1;
  localparam logic [2:0] S_EXP    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  cfg_t              cfg;
  div_stat_t         div_stat;
  logic [M_W-1:0]    div_q;
  logic              div_start;

  logic [2:0]        state;
  logic [RATE_W-1:0] rate;
  logic [VCO_W-1:0]  vco;
  logic [VCO_W-1:0]  vco_try;
  logic [PROD_W-1:0] prod;
  logic [N_W-1:0]    n;
  logic [E_W-1:0]    e;
  logic              any_exp;
  logic [ST_W-1:0]   res_status;
  logic [M_W-1:0]    res_m;
  logic [N_W-1:0]    res_n;
  logic [E_W-1:0]    res_e;
  logic [PFD_W-1:0]  pfd_lo;
  logic [PFD_W-1:0]  pfd_hi;
  logic              cand_ok;

  plldiv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plldiv_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (cfg.ref_clk),
    .quotient (div_q),
    .stat     (div_stat)
  );

  assign s_tready = (state == S_IDLE);
  assign vco_try  = VCO_W'(rate) << e;
  assign pfd_lo   = PFD_MIN * PFD_W'(n);
  assign pfd_hi   = (PFD_MAX + PFD_W'(1)) * PFD_W'(n);
  assign cand_ok  = (prod >= {{(PROD_W-REF_W-1){1'b0}}, cfg.ref_clk, 1'b0})
                 && (prod <  {{(PROD_W-REF_W-M_W){1'b0}}, cfg.ref_clk, {M_W{1'b0}}})
                 && (PFD_W'(cfg.ref_clk) >= pfd_lo)
                 && (PFD_W'(cfg.ref_clk) <  pfd_hi);
  assign div_start = (state == S_CHECK) && cand_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      any_exp  <= 1'b0;
      e        <= '0;
      n        <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state   <= S_RANGE;
            any_exp <= 1'b0;
            e       <= '0;
          end
        end
        S_RANGE: begin
          if (rate >= cfg.out_min && VCO_W'(rate) <= cfg.vco_max) begin
            state <= S_EXP;
          end else begin
            res_status <= ST_RANGE;
            state      <= S_FINISH;
          end
        end
        S_EXP: begin
          if (vco_try >= cfg.vco_min && vco_try <= cfg.vco_max) begin
            any_exp <= 1'b1;
            n       <= 4'd1;
            state   <= S_MUL;
          end else if (e == E_MAX) begin
            res_status <= any_exp ? ST_NO_MN : ST_NO_EXP;
            state      <= S_FINISH;
          end else begin
            e <= e + 2'd1;
          end
        end
        S_MUL: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cand_ok) begin
            state <= S_DIV;
          end else if (n == N_MAX) begin
            if (e == E_MAX) begin
              res_status <= ST_NO_MN;
              state      <= S_FINISH;
            end else begin
              e     <= e + 2'd1;
              state <= S_EXP;
            end
          end else begin
            n     <= n + 4'd1;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_status <= ST_FOUND;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) rate <= s_tdata[RATE_W-1:0];
    if (state == S_EXP) vco <= vco_try;
    if (state == S_MUL) prod <= PROD_W'(vco) * PROD_W'(n);
    if (state == S_DIV && div_stat.done) begin
      res_m <= div_q;
      res_n <= n;
      res_e <= e;
    end
    if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      if (res_status == ST_FOUND) begin
        m_tdata <= {res_e, res_n, res_m, res_status};
      end else begin
        m_tdata <= {{(E_W+N_W+M_W){1'b0}}, res_status};
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_FOUND |-> m_tdata[15:2] == '0)
    else $error("failed search carries nonzero divider fields");

  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FOUND |-> m_tdata[9:2] >= 8'd2 && m_tdata[13:10] != '0)
    else $error("found result with invalid multiplier or divider");

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("input taken while divider busy");

  a_div_once: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV && div_stat.busy)
    else $error("divider start not followed by division");

endmodule
